[src/tcch_pkg.sv]
// shared constants, register indexes and helper functions for the compass heading pipeline
package tcch_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ACCEL_OFS_X = 2'd0;
  localparam logic [1:0] REG_ACCEL_OFS_Y = 2'd1;
  localparam logic [1:0] REG_ACCEL_OFS_Z = 2'd2;
  localparam logic [1:0] REG_GRAVITY     = 2'd3;

  localparam logic [14:0] GRAVITY_RESET = 15'd1000;

  // angles are q3.13 radians
  localparam int ANG_W = 17;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;

  // rotation start value with the cordic gain folded in, q.30
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // radians q3.13 to 1/128 degree, q.20
  localparam logic signed [20:0] RAD_TO_DEG128_Q20 = 21'sd938734;
  localparam logic signed [18:0] DEG128_FULL  = 19'sd46080;
  localparam logic signed [18:0] DEG128_SHIFT = 19'sd11520;

  localparam logic [14:0] UNIT_Q14 = 15'd16384;

  // magnetometer normalization per axis (x, y, z):
  // num = 4*raw + ofs, den = 25*(max-min), recip = floor(2^32/den)
  localparam logic signed [18:0] MAG_OFS [3] = '{19'sd1300, -19'sd675, -19'sd475};
  localparam logic [11:0] MAG_DEN [3] = '{12'd2800, 12'd2175, 12'd2725};
  localparam logic [10:0] MAG_HALF [3] = '{11'd1400, 11'd1087, 11'd1362};
  localparam logic [20:0] MAG_RECIP [3] = '{21'd1533916, 21'd1974697, 21'd1576134};

  // arctangent of 2^-i in q3.13
  function automatic logic signed [16:0] atan_q13(input int i);
    logic signed [16:0] a;
    case (i)
      0:       a = 17'sd6434;
      1:       a = 17'sd3798;
      2:       a = 17'sd2007;
      3:       a = 17'sd1019;
      4:       a = 17'sd511;
      5:       a = 17'sd256;
      6:       a = 17'sd128;
      7:       a = 17'sd64;
      8:       a = 17'sd32;
      9:       a = 17'sd16;
      10:      a = 17'sd8;
      11:      a = 17'sd4;
      12:      a = 17'sd2;
      13:      a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

  // shift right by s, rounding to nearest with ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

endpackage

[src/tilt_compensated_compass_heading.sv]
// Tilt-compensated compass heading. One accelerometer/magnetometer sample set is taken per
// clock and one heading leaves per clock while the output is not stalled; an item passes
// through the 18-stage square root, three levels of cordic pipelines of CORDIC_STEPS+1
// stages each, and the multiplier stages of tilt compensation and degree conversion.
// Every stage moves together: a stalled output holds the whole pipeline,
// and in_tready is low exactly while an unaccepted result sits in the output register.
// Configuration writes are taken at any clock and should happen only while the pipeline is
// empty. heading_deg is in 1/128 degree, 0 to 46079; degenerate marks a zero horizontal field.
module tilt_compensated_compass_heading #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // heading_deg
  output logic        out_tuser,  // degenerate
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import tcch_pkg::*;

  localparam int SQ_W  = 34;
  localparam int RT_W  = SQ_W / 2;
  localparam int TV_W  = 36;
  localparam int ROT_W = 33;
  localparam int HD_W  = 34;

  logic adv;

  // configuration registers
  logic signed [15:0] ofs_x_r, ofs_y_r, ofs_z_r;
  logic [14:0]        bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r <= '0;
      ofs_y_r <= '0;
      ofs_z_r <= '0;
      bias_r  <= GRAVITY_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACCEL_OFS_X: ofs_x_r <= cfg_wdata;
        REG_ACCEL_OFS_Y: ofs_y_r <= cfg_wdata;
        REG_ACCEL_OFS_Z: ofs_z_r <= cfg_wdata;
        REG_GRAVITY:     bias_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output register is full and stalled
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // stage 1: offset removal
  logic signed [17:0] ax_nxt, ay_nxt, az_nxt;
  logic signed [17:0] ax1_r, ay1_r, az1_r;
  logic               v1_r;

  assign ax_nxt = {{2{in_tdata[15]}}, in_tdata[15:0]} - {{2{ofs_x_r[15]}}, ofs_x_r};
  assign ay_nxt = {{2{in_tdata[31]}}, in_tdata[31:16]} - {{2{ofs_y_r[15]}}, ofs_y_r};
  assign az_nxt = {{2{in_tdata[47]}}, in_tdata[47:32]} - {{2{ofs_z_r[15]}}, ofs_z_r}
                  - {3'b000, bias_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r <= ax_nxt;
      ay1_r <= ay_nxt;
      az1_r <= az_nxt;
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0]    axx2_r, ayy2_r, azz2_r;
  logic signed [17:0] ax2_r, ay2_r;
  logic signed [35:0] axx_nxt, ayy_nxt, azz_nxt;
  logic               v2_r;

  assign axx_nxt = ax1_r * ax1_r;
  assign ayy_nxt = ay1_r * ay1_r;
  assign azz_nxt = az1_r * az1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      axx2_r <= axx_nxt[SQ_W-1:0];
      ayy2_r <= ayy_nxt[SQ_W-1:0];
      azz2_r <= azz_nxt[SQ_W-1:0];
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
    end
  end

  // stage 3: radicands
  logic [SQ_W-1:0]    sum_roll3_r, sum_pitch3_r;
  logic signed [17:0] ax3_r, ay3_r;
  logic               v3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_roll3_r  <= axx2_r + azz2_r;
      sum_pitch3_r <= ayy2_r + azz2_r;
      ax3_r        <= ax2_r;
      ay3_r        <= ay2_r;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // magnetometer normalization lanes, aligned with stages 1 to 3
  logic signed [15:0] mag_nrm [3];

  for (genvar k = 0; k < 3; k++) begin : g_mag
    logic signed [18:0] mnum_nxt, mnum1_r;
    logic [17:0]        mabs;
    logic               neg2_r, sat2_r, neg3_r, sat3_r;
    logic [25:0]        n2_r, n3_r;
    logic [46:0]        prod;
    logic [14:0]        q03_r;
    logic [26:0]        qden;
    logic [26:0]        rem;
    logic [14:0]        q;
    logic [15:0]        qs;

    assign mnum_nxt = {in_tdata[48+16*k+15], in_tdata[48+16*k +: 16], 2'b00} + MAG_OFS[k];
    assign mabs     = mnum1_r[18] ? 18'(-mnum1_r) : mnum1_r[17:0];

    // stage 1 numerator, stage 2 clip and scale, stage 3 reciprocal product
    always_ff @(posedge clk) begin
      if (adv) begin
        mnum1_r <= mnum_nxt;
        neg2_r  <= mnum1_r[18];
        sat2_r  <= (mabs > {6'd0, MAG_DEN[k]});
        n2_r    <= {mabs[11:0], 14'd0} + {15'd0, MAG_HALF[k]};
        neg3_r  <= neg2_r;
        sat3_r  <= sat2_r;
        n3_r    <= n2_r;
        q03_r   <= prod[46:32];
      end
    end

    assign prod = n2_r * MAG_RECIP[k];

    // one correction step on the quotient estimate
    assign qden = q03_r * MAG_DEN[k];
    assign rem  = {1'b0, n3_r} - qden;
    assign q    = q03_r + {14'd0, (rem >= {15'd0, MAG_DEN[k]})};
    assign qs   = sat3_r ? {1'b0, UNIT_Q14} : {1'b0, q};
    assign mag_nrm[k] = neg3_r ? -qs : qs;
  end

  // integer square roots
  logic              sq_roll_v, sq_pitch_v;
  logic [RT_W-1:0]   root_roll, root_pitch;
  logic [49:0]       sq_roll_tag;
  logic [33:0]       sq_pitch_tag;

  tcch_isqrt #(.DW(SQ_W), .TW(50)) u_sqrt_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (v3_r),
    .val_i  (sum_roll3_r),
    .tag_i  ({ay3_r, mag_nrm[0], mag_nrm[1]}),
    .vld_o  (sq_roll_v),
    .root_o (root_roll),
    .tag_o  (sq_roll_tag)
  );

  tcch_isqrt #(.DW(SQ_W), .TW(34)) u_sqrt_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (v3_r),
    .val_i  (sum_pitch3_r),
    .tag_i  ({ax3_r, mag_nrm[2]}),
    .vld_o  (sq_pitch_v),
    .root_o (root_pitch),
    .tag_o  (sq_pitch_tag)
  );

  // tilt angles: atan2(num, root) with a zero tilt vector giving zero
  logic signed [17:0] num_roll, num_pitch;
  logic               zero_roll, zero_pitch;
  logic               tv_roll_v, tv_pitch_v;
  logic signed [ANG_W-1:0] z_roll, z_pitch;
  logic [32:0]        tv_roll_tag;
  logic [16:0]        tv_pitch_tag;

  assign num_roll   = sq_roll_tag[49:32];
  assign num_pitch  = sq_pitch_tag[33:16];
  assign zero_roll  = (num_roll == 18'sd0) && (root_roll == '0);
  assign zero_pitch = (num_pitch == 18'sd0) && (root_pitch == '0);

  tcch_cordic #(.W(TV_W), .AW(ANG_W), .STEPS(CORDIC_STEPS), .TW(33), .VECTOR(1)) u_vec_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (sq_roll_v & sq_pitch_v),
    .x_i   ({3'b000, root_roll, 16'd0}),
    .y_i   ({{2{num_roll[17]}}, num_roll, 16'd0}),
    .z_i   ('0),
    .tag_i ({zero_roll, sq_roll_tag[31:0]}),
    .vld_o (tv_roll_v),
    .x_o   (),
    .y_o   (),
    .z_o   (z_roll),
    .tag_o (tv_roll_tag)
  );

  tcch_cordic #(.W(TV_W), .AW(ANG_W), .STEPS(CORDIC_STEPS), .TW(17), .VECTOR(1)) u_vec_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (sq_roll_v & sq_pitch_v),
    .x_i   ({3'b000, root_pitch, 16'd0}),
    .y_i   ({{2{num_pitch[17]}}, num_pitch, 16'd0}),
    .z_i   ('0),
    .tag_i ({zero_pitch, sq_pitch_tag[15:0]}),
    .vld_o (tv_pitch_v),
    .x_o   (),
    .y_o   (),
    .z_o   (z_pitch),
    .tag_o (tv_pitch_tag)
  );

  logic signed [ANG_W-1:0] roll_ang, pitch_ang;
  assign roll_ang  = tv_roll_tag[32] ? '0 : z_roll;
  assign pitch_ang = tv_pitch_tag[16] ? '0 : z_pitch;

  // sine and cosine of roll and pitch
  logic                    rot_roll_v, rot_pitch_v;
  logic signed [ROT_W-1:0] cr_raw, sr_raw, cp_raw, sp_raw;
  logic [31:0]             rot_roll_tag;
  logic [15:0]             rot_pitch_tag;

  tcch_cordic #(.W(ROT_W), .AW(ANG_W), .STEPS(CORDIC_STEPS), .TW(32), .VECTOR(0)) u_rot_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (tv_roll_v & tv_pitch_v),
    .x_i   (CORDIC_GAIN_Q30),
    .y_i   ('0),
    .z_i   (roll_ang),
    .tag_i (tv_roll_tag[31:0]),
    .vld_o (rot_roll_v),
    .x_o   (cr_raw),
    .y_o   (sr_raw),
    .z_o   (),
    .tag_o (rot_roll_tag)
  );

  tcch_cordic #(.W(ROT_W), .AW(ANG_W), .STEPS(CORDIC_STEPS), .TW(16), .VECTOR(0)) u_rot_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (tv_roll_v & tv_pitch_v),
    .x_i   (CORDIC_GAIN_Q30),
    .y_i   ('0),
    .z_i   (pitch_ang),
    .tag_i (tv_pitch_tag[15:0]),
    .vld_o (rot_pitch_v),
    .x_o   (cp_raw),
    .y_o   (sp_raw),
    .z_o   (),
    .tag_o (rot_pitch_tag)
  );

  // h0: round sine and cosine to q2.14
  logic signed [16:0] cr0_r, sr0_r, cp0_r, sp0_r;
  logic signed [15:0] mx0_r, my0_r, mz0_r;
  logic               h0_v_r;
  logic signed [63:0] cr_rnd, sr_rnd, cp_rnd, sp_rnd;

  assign cr_rnd = rnd_shr(64'(cr_raw), 16);
  assign sr_rnd = rnd_shr(64'(sr_raw), 16);
  assign cp_rnd = rnd_shr(64'(cp_raw), 16);
  assign sp_rnd = rnd_shr(64'(sp_raw), 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      cr0_r <= cr_rnd[16:0];
      sr0_r <= sr_rnd[16:0];
      cp0_r <= cp_rnd[16:0];
      sp0_r <= sp_rnd[16:0];
      mx0_r <= rot_roll_tag[31:16];
      my0_r <= rot_roll_tag[15:0];
      mz0_r <= rot_pitch_tag;
    end
  end

  // h1: first products
  logic signed [33:0] p_srsp1_r, p_srcp1_r;
  logic signed [32:0] p_mxcp1_r, p_mzsp1_r, p_mycr1_r;
  logic signed [15:0] mx1_r, mz1_r;
  logic               h1_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_srsp1_r <= sr0_r * sp0_r;
      p_srcp1_r <= sr0_r * cp0_r;
      p_mxcp1_r <= mx0_r * cp0_r;
      p_mzsp1_r <= mz0_r * sp0_r;
      p_mycr1_r <= my0_r * cr0_r;
      mx1_r     <= mx0_r;
      mz1_r     <= mz0_r;
    end
  end

  // h2: round the cross terms, form the x horizontal component
  logic signed [16:0] srsp2_r, srcp2_r;
  logic signed [31:0] mxh2_r;
  logic signed [32:0] p_mycr2_r;
  logic signed [15:0] mx2_r, mz2_r;
  logic               h2_v_r;
  logic signed [63:0] srsp_rnd, srcp_rnd;
  logic signed [32:0] mxh_sum;

  assign srsp_rnd = rnd_shr(64'(p_srsp1_r), 14);
  assign srcp_rnd = rnd_shr(64'(p_srcp1_r), 14);
  assign mxh_sum  = p_mxcp1_r + p_mzsp1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      srsp2_r   <= srsp_rnd[16:0];
      srcp2_r   <= srcp_rnd[16:0];
      mxh2_r    <= mxh_sum[31:0];
      p_mycr2_r <= p_mycr1_r;
      mx2_r     <= mx1_r;
      mz2_r     <= mz1_r;
    end
  end

  // h3: products with the rounded cross terms
  logic signed [32:0] p_mx3_r, p_mz3_r, p_mycr3_r;
  logic signed [31:0] mxh3_r;
  logic               h3_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mx3_r   <= mx2_r * srsp2_r;
      p_mz3_r   <= mz2_r * srcp2_r;
      p_mycr3_r <= p_mycr2_r;
      mxh3_r    <= mxh2_r;
    end
  end

  // h4: y horizontal component
  logic signed [31:0] mxh4_r, myh4_r;
  logic               h4_v_r;
  logic signed [32:0] myh_sum;

  assign myh_sum = p_mx3_r + p_mycr3_r - p_mz3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mxh4_r <= mxh3_r;
      myh4_r <= myh_sum[31:0];
    end
  end

  // valid bits of the compensation stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_v_r <= 1'b0;
      h1_v_r <= 1'b0;
      h2_v_r <= 1'b0;
      h3_v_r <= 1'b0;
      h4_v_r <= 1'b0;
    end else if (adv) begin
      h0_v_r <= rot_roll_v & rot_pitch_v;
      h1_v_r <= h0_v_r;
      h2_v_r <= h1_v_r;
      h3_v_r <= h2_v_r;
      h4_v_r <= h3_v_r;
    end
  end

  // heading angle atan2(myh, mxh)
  logic                    hd_v;
  logic signed [ANG_W-1:0] hd_z;
  logic [0:0]              hd_tag;
  logic                    deg_nxt;

  assign deg_nxt = (mxh4_r == 32'sd0) && (myh4_r == 32'sd0);

  tcch_cordic #(.W(HD_W), .AW(ANG_W), .STEPS(CORDIC_STEPS), .TW(1), .VECTOR(1)) u_vec_head (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (h4_v_r),
    .x_i   (HD_W'(mxh4_r)),
    .y_i   (HD_W'(myh4_r)),
    .z_i   ('0),
    .tag_i (deg_nxt),
    .vld_o (hd_v),
    .x_o   (),
    .y_o   (),
    .z_o   (hd_z),
    .tag_o (hd_tag)
  );

  // h5: radians to 1/128 degree
  logic signed [37:0] deg_prod5_r;
  logic               deg5_r;
  logic               h5_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_prod5_r <= hd_z * RAD_TO_DEG128_Q20;
      deg5_r      <= hd_tag[0];
    end
  end

  // output: negate, shift by a quarter turn, wrap into one turn
  logic signed [63:0] h128_rnd;
  logic signed [18:0] wrap_t, wrap_u, wrap_v;
  logic [15:0]        heading_nxt;
  logic [15:0]        heading_r;
  logic               deg_r;

  assign h128_rnd = rnd_shr(64'(deg_prod5_r), 20);

  always_comb begin
    wrap_t = -h128_rnd[18:0] - DEG128_SHIFT;
    if (wrap_t <= -DEG128_FULL) begin
      wrap_u = wrap_t + DEG128_FULL;
    end else if (wrap_t >= DEG128_FULL) begin
      wrap_u = wrap_t - DEG128_FULL;
    end else begin
      wrap_u = wrap_t;
    end
    wrap_v = (wrap_u < 0) ? wrap_u + DEG128_FULL : wrap_u;
    heading_nxt = deg5_r ? 16'd0 : wrap_v[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= heading_nxt;
      deg_r     <= deg5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      h5_v_r      <= hd_v;
      out_valid_r <= h5_v_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = heading_r;
  assign out_tuser  = deg_r;
endmodule

[src/tcch_isqrt.sv]
// pipelined floor square root, two radicand bits per stage, with a sideband tag
module tcch_isqrt #(
  parameter int DW = 34,
  parameter int TW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  logic [DW-1:0]     val_i,
  input  logic [TW-1:0]     tag_i,
  output logic              vld_o,
  output logic [DW/2-1:0]   root_o,
  output logic [TW-1:0]     tag_o
);
  localparam int RW  = DW / 2;
  localparam int RMW = RW + 3;

  logic [DW-1:0]  val_r  [RW+1];
  logic [RMW-1:0] rem_r  [RW+1];
  logic [RW-1:0]  root_r [RW+1];
  logic [TW-1:0]  tag_r  [RW+1];
  logic [RW:0]    vld_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[RW-1:0], vld_i};
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (adv) begin
      val_r[0]  <= val_i;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      tag_r[0]  <= tag_i;
    end
  end

  // one root bit per stage
  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RMW-1:0] cand;
    logic [RMW-1:0] trial;
    logic           ge;
    assign cand  = {rem_r[i][RMW-3:0], val_r[i][DW-1:DW-2]};
    assign trial = {1'b0, root_r[i], 2'b01};
    assign ge    = (cand >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        val_r[i+1]  <= val_r[i] << 2;
        root_r[i+1] <= {root_r[i][RW-2:0], ge};
        rem_r[i+1]  <= ge ? (cand - trial) : cand;
        tag_r[i+1]  <= tag_r[i];
      end
    end
  end

  assign vld_o  = vld_r[RW];
  assign root_o = root_r[RW];
  assign tag_o  = tag_r[RW];
endmodule

[src/tcch_cordic.sv]
// pipelined cordic, vectoring (atan2) or rotation (sine/cosine), with a sideband tag
module tcch_cordic #(
  parameter int W      = 36,
  parameter int AW     = 17,
  parameter int STEPS  = 16,
  parameter int TW     = 1,
  parameter int VECTOR = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [AW-1:0] z_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 vld_o,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [AW-1:0] z_o,
  output logic [TW-1:0]        tag_o
);
  import tcch_pkg::*;

  logic signed [W-1:0]  x_r [STEPS+1];
  logic signed [W-1:0]  y_r [STEPS+1];
  logic signed [AW-1:0] z_r [STEPS+1];
  logic [TW-1:0]        tag_r [STEPS+1];
  logic [STEPS:0]       vld_r;
  logic signed [W-1:0]  x0_nxt;
  logic signed [W-1:0]  y0_nxt;
  logic signed [AW-1:0] z0_nxt;

  // vectoring: fold the left half plane over by pi
  always_comb begin
    x0_nxt = x_i;
    y0_nxt = y_i;
    z0_nxt = z_i;
    if (VECTOR != 0 && x_i < 0) begin
      x0_nxt = -x_i;
      y0_nxt = -y_i;
      z0_nxt = (y_i >= 0) ? z_i + AW'(PI_Q13) : z_i - AW'(PI_Q13);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STEPS-1:0], vld_i};
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]   <= x0_nxt;
      y_r[0]   <= y0_nxt;
      z_r[0]   <= z0_nxt;
      tag_r[0] <= tag_i;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic                ccw;
    assign xs  = x_r[i] >>> i;
    assign ys  = y_r[i] >>> i;
    assign ccw = (VECTOR != 0) ? (y_r[i] <= 0) : (z_r[i] >= 0);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ccw) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - AW'(atan_q13(i));
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + AW'(atan_q13(i));
        end
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign vld_o = vld_r[STEPS];
  assign x_o   = x_r[STEPS];
  assign y_o   = y_r[STEPS];
  assign z_o   = z_r[STEPS];
  assign tag_o = tag_r[STEPS];
endmodule

[bench/testbench.sv]
// self-checking bench for the tilt-compensated compass heading pipeline
`timescale 1ns / 100ps

module testbench;
  import tcch_pkg::*;

  localparam int STEPS = 16;
  localparam int DRAIN = 3 * STEPS + 80;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] mz, my, mx, az, ay, ax;
  } sample_t;

  typedef struct {
    logic [15:0] heading;
    logic        degen;
  } heading_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [15:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  tilt_compensated_compass_heading #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #6 clk = ~clk;

  // predictor copy of the registers
  longint ofs_x = 0, ofs_y = 0, ofs_z = 0, grav = 1000;

  sample_t  pending_q[$];
  heading_t heading_q[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit hold_req = 0;
  bit pause_drv = 0;
  int gap = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >= 0 ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint round_shr(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    return v >= 0 ? ((v + h) >>> s) : -(((-v) + h) >>> s);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan_tbl(int i);
    longint t[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return i < 14 ? t[i] : 0;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 25736 : -25736;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_tbl(i);
      end else begin
        x -= ys; y += xs; z -= arctan_tbl(i);
      end
    end
    return z;
  endfunction

  function automatic longint tilt_of(longint num, longint root);
    if (num == 0 && root == 0) return 0;
    return vector_angle(root * 65536, num * 65536);
  endfunction

  function automatic void rotate_unit(input longint ang, output longint s, output longint c);
    longint x, y, z, xs, ys;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_tbl(i);
      end else begin
        x += ys; y -= xs; z += arctan_tbl(i);
      end
    end
    c = round_shr(x, 16);
    s = round_shr(y, 16);
  endfunction

  function automatic longint mag_unit(longint raw, longint lo, longint hi);
    longint num, den, a, q;
    num = 4 * raw - 25 * (lo + hi);
    den = 25 * (hi - lo);
    a = (num < 0 ? -num : num) * 16384;
    q = (a + den / 2) / den;
    if (q > 16384) q = 16384;
    return num < 0 ? -q : q;
  endfunction

  function automatic heading_t predict_heading(sample_t s);
    heading_t r;
    longint ax, ay, az, mx, my, mz, roll, pitch, sr, cr, sp, cp, srsp, srcp, mxh, myh, h, v;
    ax = longint'(s.ax) - ofs_x;
    ay = longint'(s.ay) - ofs_y;
    az = longint'(s.az) - ofs_z - grav;
    mx = mag_unit(s.mx, -82, 30);
    my = mag_unit(s.my, -30, 57);
    mz = mag_unit(s.mz, -45, 64);
    roll = tilt_of(ay, int_sqrt(ax * ax + az * az));
    pitch = tilt_of(ax, int_sqrt(ay * ay + az * az));
    rotate_unit(roll, sr, cr);
    rotate_unit(pitch, sp, cp);
    srsp = round_shr(sr * sp, 14);
    srcp = round_shr(sr * cp, 14);
    mxh = mx * cp + mz * sp;
    myh = mx * srsp + my * cr - mz * srcp;
    if (mxh == 0 && myh == 0) begin
      r.heading = 0;
      r.degen = 1;
    end else begin
      h = round_shr(vector_angle(mxh, myh) * 938734, 20);
      v = (-h - 11520) % 46080;
      if (v < 0) v += 46080;
      r.heading = v[15:0];
      r.degen = 0;
    end
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // driver: one transfer per handshake, random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        heading_q.push_back(predict_heading(sample_t'(in_tdata)));
        void'(pending_q.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_tvalid <= 0;
        end else if (!pause_drv && pending_q.size() > 0) begin
          in_tdata <= pending_q[0];
          in_tvalid <= 1;
          gap <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3)) : 0;
        end else in_tvalid <= 0;
      end
    end
  end

  // monitor: random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (heading_q.size() == 0) begin
          $display("%0t unexpected transfer: actual %0d/%0b", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          if (out_tdata !== heading_q[0].heading)
            begin
              $display("%0t heading mismatch: expected %0d actual %0d", $time,
                       heading_q[0].heading, out_tdata);
              errors++;
            end
          if (out_tuser !== heading_q[0].degen) begin
            $display("%0t degenerate mismatch: expected %0b actual %0b", $time,
                     heading_q[0].degen, out_tuser);
            errors++;
          end
          void'(heading_q.pop_front());
        end
      end
      if (hold_req && hold_off == 0) begin
        hold_off <= 300;
        out_tready <= 0;
      end else if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        out_tready <= 0;
      end else begin
        hold_off <= 0;
        out_tready <= ($urandom_range(0, 3) != 0) ||
                      (($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1) && $urandom_range(0, 1);
      end
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    s = {$urandom, $urandom, $urandom};
    // keep magnetometer mostly inside its calibration band
    if ($urandom_range(0, 3) != 0) begin
      s.mx = 16'(int'($urandom_range(0, 112)) - 82);
      s.my = 16'(int'($urandom_range(0, 87)) - 30);
      s.mz = 16'(int'($urandom_range(0, 109)) - 45);
    end
    if ($urandom_range(0, 3) == 0) begin
      s.ax = 16'(int'($urandom_range(0, 4000)) - 2000);
      s.ay = 16'(int'($urandom_range(0, 4000)) - 2000);
      s.az = 16'(int'($urandom_range(0, 4000)) - 2000);
    end
    return s;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || heading_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_ACCEL_OFS_X: ofs_x = longint'($signed(val));
      REG_ACCEL_OFS_Y: ofs_y = longint'($signed(val));
      REG_ACCEL_OFS_Z: ofs_z = longint'($signed(val));
      REG_GRAVITY:     grav = longint'(val[14:0]);
    endcase
  endtask

  task automatic push(input logic signed [15:0] ax, ay, az, mx, my, mz);
    sample_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.mx = mx; s.my = my; s.mz = mz;
    pending_q.push_back(s);
  endtask

  initial begin
    logic [15:0] settings[5][4];
    settings = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'd1000},
      '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF},
      '{16'h8000, 16'h7FFF, 16'h8000, 16'h0000},
      '{16'd120, -16'sd75, 16'd300, 16'd16384},
      '{16'h0000, 16'h0000, -16'sd1000, 16'h0000}};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    // directed corners
    push(0, 0, 1000, 0, 0, 0);
    push(0, 0, 0, 0, 0, 0);
    push(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push(0, 0, 2000, 30, 57, 64);
    push(0, 0, 2000, -82, -30, -45);
    push(0, 0, 2000, -26, 13, 9);
    push(0, 0, 2000, 50, 14, 10);
    push(0, 0, 2000, -26, 14, 10);
    push(0, 0, 2000, -90, 14, 10);
    push(1000, 0, 1000, -26, 13, 9);
    push(0, 1000, 1000, 20, -20, 60);
    push(-1000, -1000, 1000, 0, 50, -40);
    push(0, 0, -5000, 10, 10, 10);
    push(5000, 0, 1000, 10, 40, 10);
    wait_idle();
    // pressure: long receiver hold-off with input flooding
    hold_req = 1;
    for (int i = 0; i < 100; i++) pending_q.push_back(rand_sample());
    wait (hold_off != 0);
    hold_req = 0;
    wait_idle();
    for (int p = 0; p < 5; p++) begin
      for (int r = 0; r < 4; r++) write_reg(r[1:0], settings[p][r]);
      push(0, 0, 0, -26, 13, 9);
      for (int i = 0; i < 60; i++) pending_q.push_back(rand_sample());
      wait_idle();
    end
    // sender pause with samples already queued, then release and drain
    pause_drv = 1;
    for (int i = 0; i < 40; i++) pending_q.push_back(rand_sample());
    repeat (20) @(posedge clk);
    pause_drv = 0;
    wait_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
